### hw/rtl/pixel_format_converter_unit_assert.svh
// Assertion macros for the pixel format converter.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef PIXEL_FORMAT_CONVERTER_UNIT_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PFC_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pfc assertion failed");

// Next-cycle implication, checked out of reset.
`define PFC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pfc assertion failed");

`endif

### hw/rtl/pfc_pkg.sv
// Shared types, constants and helper functions of the pixel format converter.
// Used by every module of the block; depends on nothing.
package pfc_pkg;

  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CH_NUM    = 4;
  localparam int unsigned SLOT_W    = 9;
  localparam int unsigned LAYOUT_W  = CH_NUM * SLOT_W;
  localparam int unsigned CHAN_BITS = 8;
  localparam int unsigned CH_ALPHA  = 3;
  localparam int unsigned NUM_W     = 16;
  localparam int unsigned RECIP_W   = 25;
  localparam int unsigned RECIP_SH  = 24;
  localparam int unsigned PROD_W    = NUM_W + RECIP_W;

  localparam logic [CHAN_BITS-1:0] CHAN_FULL = 8'd255;

  localparam logic [LAYOUT_W-1:0] LAYOUT_RESET = 36'h8C4021110;

  // Reciprocals ceil(2^24 / (2^w - 1)); exact for all numerators used here.
  localparam logic [RECIP_W-1:0] RECIP_1   = 25'(2**RECIP_SH);
  localparam logic [RECIP_W-1:0] RECIP_3   = 25'((2**RECIP_SH + 2) / 3);
  localparam logic [RECIP_W-1:0] RECIP_7   = 25'((2**RECIP_SH + 6) / 7);
  localparam logic [RECIP_W-1:0] RECIP_15  = 25'((2**RECIP_SH + 14) / 15);
  localparam logic [RECIP_W-1:0] RECIP_31  = 25'((2**RECIP_SH + 30) / 31);
  localparam logic [RECIP_W-1:0] RECIP_63  = 25'((2**RECIP_SH + 62) / 63);
  localparam logic [RECIP_W-1:0] RECIP_127 = 25'((2**RECIP_SH + 126) / 127);

  typedef enum logic [1:0] {
    CFG_SRC_LAYOUT = 2'd0,
    CFG_DST_LAYOUT = 2'd1,
    CFG_COPY       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } lane_en_t;

  function automatic logic [3:0] slot_width(input logic [SLOT_W-1:0] slot);
    logic [3:0] w;
    w = slot[8:5];
    return (w > 4'd8) ? 4'd8 : w;
  endfunction

  function automatic logic [4:0] slot_shift(input logic [SLOT_W-1:0] slot);
    return slot[4:0];
  endfunction

  function automatic logic [CHAN_BITS-1:0] width_mask(input logic [3:0] w);
    logic [CHAN_BITS:0] m;
    m = (9'h1 << w) - 9'h1;
    return m[CHAN_BITS-1:0];
  endfunction

  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] w);
    logic [RECIP_W-1:0] r;
    case (w)
      4'd2:    r = RECIP_3;
      4'd3:    r = RECIP_7;
      4'd4:    r = RECIP_15;
      4'd5:    r = RECIP_31;
      4'd6:    r = RECIP_63;
      4'd7:    r = RECIP_127;
      default: r = RECIP_1;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/pfc_lane.sv
// One color channel lane: extract, widen to 8 bits and truncate to the destination width.
// Four register stages; uses pfc_pkg.
module pfc_lane (
  input  logic                                clk_i,
  input  pfc_pkg::lane_en_t                   en_i,
  input  logic [pfc_pkg::PIX_W-1:0]           pix_i,
  input  logic [pfc_pkg::SLOT_W-1:0]          src_slot_i,
  input  logic [pfc_pkg::SLOT_W-1:0]          dst_slot_i,
  input  logic                                alpha_i,
  output logic [pfc_pkg::CHAN_BITS-1:0]       part_o
);

  logic [3:0]                        sw_d;
  logic [pfc_pkg::PIX_W-1:0]         shifted;
  logic [pfc_pkg::CHAN_BITS-1:0]     raw_d;
  logic [pfc_pkg::CHAN_BITS-1:0]     raw1_q, raw2_q, raw3_q;
  logic [3:0]                        sw1_q, sw2_q, sw3_q;
  logic [pfc_pkg::CHAN_BITS-1:0]     top;
  logic [pfc_pkg::NUM_W-1:0]         n_d, n2_q;
  logic [pfc_pkg::PROD_W-1:0]        prod;
  logic [pfc_pkg::CHAN_BITS-1:0]     q3_q;
  logic [pfc_pkg::CHAN_BITS-1:0]     full;
  logic [3:0]                        dw;
  logic [pfc_pkg::CHAN_BITS-1:0]     part_d, part_q;

  assign sw_d    = pfc_pkg::slot_width(src_slot_i);
  assign shifted = pix_i >> pfc_pkg::slot_shift(src_slot_i);
  assign raw_d   = shifted[pfc_pkg::CHAN_BITS-1:0] & pfc_pkg::width_mask(sw_d);

  assign top = pfc_pkg::width_mask(sw1_q);
  assign n_d = (pfc_pkg::NUM_W'(raw1_q) * 16'd255) + pfc_pkg::NUM_W'(top[7:1]);

  assign prod = pfc_pkg::PROD_W'(n2_q) * pfc_pkg::PROD_W'(pfc_pkg::recip(sw2_q));

  assign dw = pfc_pkg::slot_width(dst_slot_i);

  always_comb begin
    if (sw3_q == 4'd0) begin
      full = alpha_i ? pfc_pkg::CHAN_FULL : '0;
    end else if (sw3_q == 4'd8) begin
      full = raw3_q;
    end else begin
      full = q3_q;
    end
    if (dw == 4'd0) begin
      part_d = '0;
    end else begin
      part_d = full >> (4'd8 - dw);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      raw1_q <= raw_d;
      sw1_q  <= sw_d;
    end
    if (en_i.s2) begin
      n2_q   <= n_d;
      raw2_q <= raw1_q;
      sw2_q  <= sw1_q;
    end
    if (en_i.s3) begin
      q3_q   <= prod[pfc_pkg::RECIP_SH +: pfc_pkg::CHAN_BITS];
      raw3_q <= raw2_q;
      sw3_q  <= sw2_q;
    end
    if (en_i.s4) begin
      part_q <= part_d;
    end
  end

  assign part_o = part_q;

endmodule

### hw/rtl/pfc_pack.sv
// Output stage: places the four channel parts at their destination shifts, or passes the word.
// Uses pfc_pkg.
module pfc_pack (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [pfc_pkg::CHAN_BITS-1:0]          parts_i [pfc_pkg::CH_NUM],
  input  logic [pfc_pkg::LAYOUT_W-1:0]           dst_layout_i,
  input  logic                                   copy_i,
  input  logic [pfc_pkg::PIX_W-1:0]              pix_i,
  output logic [pfc_pkg::PIX_W-1:0]              data_o
);

  logic [pfc_pkg::PIX_W-1:0] data_d, data_q;
  logic [38:0]               placed [pfc_pkg::CH_NUM];

  always_comb begin
    data_d = '0;
    for (int ch = 0; ch < pfc_pkg::CH_NUM; ch++) begin
      placed[ch] = 39'(parts_i[ch]) <<
                   pfc_pkg::slot_shift(dst_layout_i[ch*pfc_pkg::SLOT_W +: pfc_pkg::SLOT_W]);
      data_d = data_d | placed[ch][pfc_pkg::PIX_W-1:0];
    end
    if (copy_i) begin
      data_d = pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### hw/rtl/pixel_format_converter_unit.sv
// Top level of the pixel format converter: configuration registers, stage handshake, lanes.
// Depends on pfc_pkg, pfc_lane, pfc_pack and pixel_format_converter_unit_assert.svh.
//
//   channel   direction  content
//   s_axis    in         source pixel word, 32 bits
//   m_axis    out        destination pixel word, 32 bits
//   cfg       in         write of source layout, destination layout or copy flag
//
// Every word passes five register stages: extract, numerator, reciprocal multiply,
// truncate, place. One word is taken in every cycle unless a stall on m_axis has filled every stage.
// Reset clears the stage valid bits and loads the ARGB8888 layouts with copy off.
// A stall on m_axis holds each full stage; empty stages keep filling behind it.
module pixel_format_converter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pfc_pkg::PIX_W-1:0]           s_axis_tdata,   // [31:0] source_pixel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pfc_pkg::PIX_W-1:0]           m_axis_tdata,   // [31:0] dest_pixel
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [pfc_pkg::LAYOUT_W-1:0]        cfg_data_i
);

  localparam int unsigned NSTAGE = 5;

  logic [pfc_pkg::LAYOUT_W-1:0] src_layout_q, dst_layout_q;
  logic                         copy_q;
  logic [NSTAGE-1:0]            valid_q;
  logic [NSTAGE:0]              ready;
  logic [NSTAGE-1:0]            en;
  logic [NSTAGE-1:0]            in_valid;
  pfc_pkg::lane_en_t            lane_en;
  logic [pfc_pkg::PIX_W-1:0]    pix_q [NSTAGE-1];
  logic [pfc_pkg::CHAN_BITS-1:0] parts [pfc_pkg::CH_NUM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_layout_q <= pfc_pkg::LAYOUT_RESET;
      dst_layout_q <= pfc_pkg::LAYOUT_RESET;
      copy_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfc_pkg::CFG_SRC_LAYOUT: src_layout_q <= cfg_data_i;
        pfc_pkg::CFG_DST_LAYOUT: dst_layout_q <= cfg_data_i;
        pfc_pkg::CFG_COPY:       copy_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ready[NSTAGE] = m_axis_tready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    in_valid[0] = s_axis_tvalid;
    for (int k = 1; k < NSTAGE; k++) begin
      in_valid[k] = valid_q[k-1];
    end
    en = in_valid & ready[NSTAGE-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (ready[k]) begin
          valid_q[k] <= in_valid[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pix_q[0] <= s_axis_tdata;
    end
    for (int k = 1; k < NSTAGE - 1; k++) begin
      if (en[k]) begin
        pix_q[k] <= pix_q[k-1];
      end
    end
  end

  assign lane_en.s1 = en[0];
  assign lane_en.s2 = en[1];
  assign lane_en.s3 = en[2];
  assign lane_en.s4 = en[3];

  for (genvar gi = 0; gi < pfc_pkg::CH_NUM; gi++) begin : g_lane
    pfc_lane u_lane (
      .clk_i      (clk_i),
      .en_i       (lane_en),
      .pix_i      (s_axis_tdata),
      .src_slot_i (src_layout_q[gi*pfc_pkg::SLOT_W +: pfc_pkg::SLOT_W]),
      .dst_slot_i (dst_layout_q[gi*pfc_pkg::SLOT_W +: pfc_pkg::SLOT_W]),
      .alpha_i    (gi == pfc_pkg::CH_ALPHA),
      .part_o     (parts[gi])
    );
  end

  pfc_pack u_pack (
    .clk_i        (clk_i),
    .en_i         (en[NSTAGE-1]),
    .parts_i      (parts),
    .dst_layout_i (dst_layout_q),
    .copy_i       (copy_q),
    .pix_i        (pix_q[NSTAGE-2]),
    .data_o       (m_axis_tdata)
  );

  assign s_axis_tready = ready[0];
  assign m_axis_tvalid = valid_q[NSTAGE-1];

`include "pixel_format_converter_unit_assert.svh"

  `PFC_ASSERT_NOW(a_full_stall_blocks_input, (&valid_q) && !m_axis_tready, !s_axis_tready)
  `PFC_ASSERT_NEXT(a_stalled_stage_holds, valid_q[3] && !ready[4], valid_q[3] && valid_q[4])
  `PFC_ASSERT_NEXT(a_output_moves_stage, m_axis_tvalid && m_axis_tready && !valid_q[3],
                   !m_axis_tvalid)

endmodule

### tb/sv/pixel_format_converter_unit_tb.sv
// Self-checking testbench of pixel_format_converter_unit: directed and random pixel words are
// repacked by a behavioral model that follows every layout write, and each output word is compared.
// Depends on pfc_pkg and the RTL of the block.
module pixel_format_converter_unit_tb;
  import pfc_pkg::*;

  localparam int unsigned GAP_MAX         = 14;
  localparam int unsigned LATENCY         = 5;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned NUM_PHASES      = 37;
  localparam int unsigned WORDS_PER_PHASE = 50;
  localparam logic [1:0]  CFG_IDX_SPARE   = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [PIX_W-1:0]    s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [PIX_W-1:0]    m_axis_tdata;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [LAYOUT_W-1:0] cfg_data_i;

  logic [LAYOUT_W-1:0] src_fmt;
  logic [LAYOUT_W-1:0] dst_fmt;
  bit                  copy_mode;
  bit                  src_idle_on;
  bit                  snk_idle_on;
  logic [PIX_W-1:0]    expected_pixels[$];
  int unsigned         mismatch_count = 0;
  int unsigned         quiet_cycles = 0;

  pixel_format_converter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [LAYOUT_W-1:0] pack_layout(
    logic [3:0] r_w, logic [4:0] r_s, logic [3:0] g_w, logic [4:0] g_s,
    logic [3:0] b_w, logic [4:0] b_s, logic [3:0] a_w, logic [4:0] a_s);
    return {a_w, a_s, b_w, b_s, g_w, g_s, r_w, r_s};
  endfunction

  function automatic int unsigned layout_width(logic [LAYOUT_W-1:0] layout, int unsigned ch);
    logic [3:0] w;
    w = layout[ch*SLOT_W+5 +: 4];
    return (w > CHAN_BITS) ? CHAN_BITS : int'(w);
  endfunction

  function automatic int unsigned layout_shift(logic [LAYOUT_W-1:0] layout, int unsigned ch);
    return int'(layout[ch*SLOT_W +: 5]);
  endfunction

  function automatic logic [7:0] expand_to_byte(logic [7:0] v, int unsigned w);
    int unsigned top;
    if (w == 0) return 8'd0;
    if (w >= CHAN_BITS) return v;
    top = (1 << w) - 1;
    return 8'(((v & top) * CHAN_FULL + top / 2) / top);
  endfunction

  function automatic logic [PIX_W-1:0] repack_pixel(logic [PIX_W-1:0] pix);
    logic [63:0]  wide_pix;
    logic [63:0]  packed_pix;
    logic [7:0]   raw;
    logic [7:0]   full;
    int unsigned  sw;
    int unsigned  dw;
    if (copy_mode) return pix;
    wide_pix = {32'd0, pix};
    packed_pix = '0;
    for (int unsigned ch = 0; ch < CH_NUM; ch++) begin
      sw = layout_width(src_fmt, ch);
      dw = layout_width(dst_fmt, ch);
      raw = 8'((wide_pix >> layout_shift(src_fmt, ch)) & ((64'd1 << sw) - 64'd1));
      if (sw == 0) begin
        full = (ch == CH_ALPHA) ? CHAN_FULL : 8'd0;
      end else begin
        full = expand_to_byte(raw, sw);
      end
      if (dw != 0) begin
        packed_pix |= 64'(full >> (CHAN_BITS - dw)) << layout_shift(dst_fmt, ch);
      end
    end
    return packed_pix[PIX_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
    $display("mismatch: %s, got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(GAP_MAX, 0) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pixels.push_back(repack_pixel(pix));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_pixels.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [LAYOUT_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_SRC_LAYOUT: src_fmt = value;
      CFG_DST_LAYOUT: dst_fmt = value;
      CFG_COPY:       copy_mode = value[0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_formats(logic [LAYOUT_W-1:0] src, logic [LAYOUT_W-1:0] dst, bit copy);
    wait_drained();
    write_reg(CFG_SRC_LAYOUT, src);
    write_reg(CFG_DST_LAYOUT, dst);
    write_reg(CFG_COPY, LAYOUT_W'(copy));
  endtask

  task automatic test_reset_formats();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8040_2010);
  endtask

  task automatic test_widening();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    set_formats(pack_layout(5, 11, 6, 5, 5, 0, 0, 0), LAYOUT_RESET, 1'b0);
    send_pixel(32'h0000_FFFF);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_A5A5);
    set_formats(pack_layout(1, 0, 2, 1, 3, 3, 7, 6), LAYOUT_RESET, 1'b0);
    send_pixel(32'h0000_2AAA);
    send_pixel(32'h0000_1FFF);
  endtask

  task automatic test_truncation();
    set_formats(LAYOUT_RESET, pack_layout(4, 8, 4, 4, 4, 0, 4, 12), 1'b0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h89AB_CDEF);
    set_formats(LAYOUT_RESET, pack_layout(3, 5, 3, 2, 2, 0, 0, 0), 1'b0);
    send_pixel(32'h1234_5678);
  endtask

  task automatic test_odd_layouts();
    // Width fields above eight, which are clamped to eight bits, in both layouts.
    set_formats(pack_layout(15, 0, 9, 8, 12, 16, 15, 24),
                pack_layout(9, 16, 15, 8, 10, 0, 13, 24), 1'b0);
    send_pixel(32'hFEDC_BA98);
    send_pixel(32'h0102_0304);
    // Channels reaching past bit 31 on both sides.
    set_formats(pack_layout(8, 28, 0, 0, 0, 0, 8, 31),
                pack_layout(8, 28, 0, 0, 0, 0, 8, 30), 1'b0);
    send_pixel(32'hF000_0000);
    send_pixel(32'hFFFF_FFFF);
    // Overlapping destination fields are ORed; the alpha field is absent.
    set_formats(LAYOUT_RESET, pack_layout(8, 0, 8, 0, 8, 4, 0, 24), 1'b0);
    send_pixel(32'h5A3C_0F81);
    send_pixel(32'hC300_00FF);
  endtask

  task automatic test_copy_and_spare_index();
    set_formats(pack_layout(5, 11, 6, 5, 5, 0, 0, 0), pack_layout(5, 11, 6, 5, 5, 0, 0, 0), 1'b1);
    send_pixel(32'hDEAD_BEEF);
    wait_drained();
    write_reg(CFG_IDX_SPARE, 36'h0_0000_0000);
    send_pixel(32'h0123_4567);
    set_formats(LAYOUT_RESET, pack_layout(5, 11, 6, 5, 5, 0, 0, 0), 1'b0);
    wait_drained();
    write_reg(CFG_IDX_SPARE, 36'hF_FFFF_FFFF);
    send_pixel(32'h7F80_817E);
  endtask

  task automatic test_random_formats();
    logic [LAYOUT_W-1:0] common_fmts[8];
    logic [LAYOUT_W-1:0] src;
    logic [LAYOUT_W-1:0] dst;
    logic [PIX_W-1:0]    pix;
    bit                  copy;
    common_fmts[0] = LAYOUT_RESET;
    common_fmts[1] = pack_layout(8, 0, 8, 8, 8, 16, 8, 24);
    common_fmts[2] = pack_layout(5, 11, 6, 5, 5, 0, 0, 0);
    common_fmts[3] = pack_layout(5, 10, 5, 5, 5, 0, 1, 15);
    common_fmts[4] = pack_layout(4, 8, 4, 4, 4, 0, 4, 12);
    common_fmts[5] = pack_layout(3, 5, 3, 2, 2, 0, 0, 0);
    common_fmts[6] = pack_layout(8, 16, 8, 8, 8, 0, 0, 0);
    common_fmts[7] = pack_layout(8, 24, 8, 16, 8, 8, 8, 0);
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      copy = 1'b0;
      if (phase == 0) begin
        src = '0;
        dst = '1;
      end else if (phase == 1) begin
        src = '1;
        dst = '0;
      end else begin
        src = ($urandom_range(2, 0) != 0) ? common_fmts[$urandom_range(7, 0)]
                                          : LAYOUT_W'({$urandom, $urandom});
        dst = ($urandom_range(2, 0) != 0) ? common_fmts[$urandom_range(7, 0)]
                                          : LAYOUT_W'({$urandom, $urandom});
        if ($urandom_range(5, 0) == 0) begin
          dst  = src;
          copy = 1'b1;
        end
      end
      src_idle_on = ($urandom_range(3, 0) != 0);
      snk_idle_on = ($urandom_range(3, 0) != 0);
      set_formats(src, dst, copy);
      if (phase % 6 == 3) begin
        write_reg(CFG_IDX_SPARE, LAYOUT_W'({$urandom, $urandom}));
      end
      for (int unsigned i = 0; i < WORDS_PER_PHASE; i++) begin
        pix = $urandom;
        if ($urandom_range(15, 0) == 0) begin
          pix = $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end
        send_pixel(pix);
        if (i == WORDS_PER_PHASE / 2 && phase % 5 == 2) begin
          wait_drained();
        end
      end
    end
  endtask

  initial begin : result_checker
    int unsigned      stall;
    logic [PIX_W-1:0] want;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = snk_idle_on ? $urandom_range(GAP_MAX, 0) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (expected_pixels.size() == 0) begin
        report_mismatch("word with nothing pending", m_axis_tdata, 'x);
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata !== want) begin
          report_mismatch("dest_pixel", m_axis_tdata, want);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_SRC_LAYOUT;
    cfg_data_i    <= '0;
    src_fmt       = LAYOUT_RESET;
    dst_fmt       = LAYOUT_RESET;
    copy_mode     = 1'b0;
    src_idle_on   = 1'b1;
    snk_idle_on   = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_formats();
    test_widening();
    test_truncation();
    test_odd_layouts();
    test_copy_and_spare_index();
    test_random_formats();
    wait_drained();
    repeat (LATENCY + 3) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
